### hw/rtl/fpwm_pkg.sv
// Shared types and constants for the frame position-weighted means block.
`default_nettype none
package fpwm_pkg;

    localparam int IN_W    = 16;  // pixel width
    localparam int CFG_W   = 13;  // frame size register width
    localparam int ISUM_W  = 40;  // intensity sum
    localparam int WSUM_W  = 52;  // position-weighted sums
    localparam int N_W     = 26;  // pixel count, 8191 * 8191 fits
    localparam int MI_W    = 24;  // mean intensity result
    localparam int MW_W    = 36;  // weighted mean results
    localparam int APB_W   = 32;

    // frame queue, depth must be a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // sums of one finished frame and its pixel count
    typedef struct packed {
        logic [ISUM_W-1:0] isum;
        logic [WSUM_W-1:0] csum;
        logic [WSUM_W-1:0] rsum;
        logic [N_W-1:0]    n;
    } t_frame;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage
`default_nettype wire

### hw/rtl/fpwm_front.sv
// Front end: column/row tracking and moment accumulation per pixel item.
`default_nettype none
module fpwm_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [fpwm_pkg::IN_W-1:0]  i_pixel,
    input  wire logic [fpwm_pkg::CFG_W-1:0] i_width,
    input  wire logic [fpwm_pkg::CFG_W-1:0] i_height,
    output logic                            o_push,
    output fpwm_pkg::t_frame                o_frame
);
    import fpwm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CPW = IN_W + CW;
    localparam int RPW = IN_W + RW;
    localparam logic [16:0] MAXW = 17'(MAX_WIDTH);
    localparam logic [16:0] MAXH = 17'(MAX_HEIGHT);

    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [ISUM_W-1:0] r_isum, n_isum, sum_i;
    logic [WSUM_W-1:0] r_csum, n_csum, sum_c;
    logic [WSUM_W-1:0] r_rsum, n_rsum, sum_r;
    logic [CFG_W-1:0]  w, h;
    logic [CPW-1:0]    prod_c;
    logic [RPW-1:0]    prod_r;
    logic              last_col, last_row;

    // zero acts as one, oversize saturates
    always_comb begin
        if (i_width == '0) begin
            w = CFG_W'(1);
        end else if (17'(i_width) > MAXW) begin
            w = CFG_W'(MAXW);
        end else begin
            w = i_width;
        end
        if (i_height == '0) begin
            h = CFG_W'(1);
        end else if (17'(i_height) > MAXH) begin
            h = CFG_W'(MAXH);
        end else begin
            h = i_height;
        end
    end

    assign prod_c   = CPW'(i_pixel) * CPW'(r_col);
    assign prod_r   = RPW'(i_pixel) * RPW'(r_row);
    assign sum_i    = r_isum + ISUM_W'(i_pixel);
    assign sum_c    = r_csum + WSUM_W'(prod_c);
    assign sum_r    = r_rsum + WSUM_W'(prod_r);
    // counts past a shrunk size end the line or frame at once
    assign last_col = 17'(r_col) >= (17'(w) - 17'd1);
    assign last_row = 17'(r_row) >= (17'(h) - 17'd1);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_isum = r_isum;
        n_csum = r_csum;
        n_rsum = r_rsum;
        o_push = 1'b0;
        if (i_accept) begin
            n_isum = sum_i;
            n_csum = sum_c;
            n_rsum = sum_r;
            if (!last_col) begin
                n_col = r_col + 1'b1;
            end else begin
                n_col = '0;
                if (!last_row) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_row  = '0;
                    n_isum = '0;
                    n_csum = '0;
                    n_rsum = '0;
                    o_push = 1'b1;
                end
            end
        end
    end

    assign o_frame.isum = sum_i;
    assign o_frame.csum = sum_c;
    assign o_frame.rsum = sum_r;
    assign o_frame.n    = N_W'(w) * N_W'(h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_isum <= '0;
            r_csum <= '0;
            r_rsum <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_isum <= n_isum;
            r_csum <= n_csum;
            r_rsum <= n_rsum;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fpwm_queue.sv
// Short queue of finished frame sums between front and back.
`default_nettype none
module fpwm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire fpwm_pkg::t_frame i_data,
    input  wire logic             i_pop,
    output fpwm_pkg::t_frame      o_data,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [fpwm_pkg::Q_CW-1:0] o_count
);
    import fpwm_pkg::*;

    t_frame          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_CW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = r_cnt == Q_CW'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fpwm_div.sv
// One bit-per-cycle restoring divider lane: floor(sum * 2^FRAC_BITS / n).
`default_nettype none
module fpwm_div #(
    parameter int FRAC_BITS = 8,
    parameter int Q_W       = 36
) (
    input  wire logic                        i_clk,
    input  wire fpwm_pkg::t_div_ctl          i_ctl,
    input  wire logic [fpwm_pkg::WSUM_W-1:0] i_sum,
    input  wire logic [fpwm_pkg::N_W-1:0]    i_den,
    output logic [Q_W-1:0]                   o_quot
);
    import fpwm_pkg::*;

    localparam int NUM_W = WSUM_W + FRAC_BITS;

    logic [NUM_W-1:0] r_num;
    logic [N_W-1:0]   r_rem;
    logic [N_W-1:0]   r_den;
    logic [Q_W-1:0]   r_q;
    logic [N_W:0]     trial;
    logic             fits;

    assign trial  = {r_rem, r_num[NUM_W-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= NUM_W'(i_sum) << FRAC_BITS;
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= '0;
        end else if (i_ctl.step) begin
            r_num <= r_num << 1;
            // remainder stays below the divisor, so it fits N_W bits
            r_rem <= fits ? N_W'(trial - {1'b0, r_den}) : N_W'(trial);
            r_q   <= {r_q[Q_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fpwm_back.sv
// Back end: takes frame sums from the queue, divides, holds the result item.
`default_nettype none
module fpwm_back #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_empty,
    input  wire fpwm_pkg::t_frame          i_q_data,
    output logic                           o_q_pop,
    input  wire logic                      i_pop,
    output logic                           o_empty,
    output logic [fpwm_pkg::MI_W-1:0]      o_mean_intensity,
    output logic [fpwm_pkg::MW_W-1:0]      o_mean_column_weighted,
    output logic [fpwm_pkg::MW_W-1:0]      o_mean_row_weighted
);
    import fpwm_pkg::*;

    localparam int ITER  = WSUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(ITER + 1);

    t_back_state      r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_div_ctl         ctl;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        ctl.start = 1'b0;
        ctl.step  = 1'b0;
        o_q_pop   = 1'b0;
        o_empty   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    ctl.start = 1'b1;
                    n_cnt     = CNT_W'(ITER);
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                ctl.step = 1'b1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_empty = 1'b0;
                if (i_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    fpwm_div #(.FRAC_BITS(FRAC_BITS), .Q_W(MI_W)) u_div_i (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_sum  (WSUM_W'(i_q_data.isum)),
        .i_den  (i_q_data.n),
        .o_quot (o_mean_intensity)
    );

    fpwm_div #(.FRAC_BITS(FRAC_BITS), .Q_W(MW_W)) u_div_c (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_sum  (i_q_data.csum),
        .i_den  (i_q_data.n),
        .o_quot (o_mean_column_weighted)
    );

    fpwm_div #(.FRAC_BITS(FRAC_BITS), .Q_W(MW_W)) u_div_r (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_sum  (i_q_data.rsum),
        .i_den  (i_q_data.n),
        .o_quot (o_mean_row_weighted)
    );

endmodule
`default_nettype wire

### hw/rtl/frame_position_weighted_means.sv
// With the back end idle, the last pixel of a frame pushes its sums into the frame queue; the
// back end then pops them, starts the dividers and holds the result after 52 + FRAC_BITS steps.
// Throughput: one pixel item per cycle while the two-entry frame queue is not full; a full
// queue stalls all input, so frames shorter than the divide time or unpopped results stall it.
// Reset (synchronous, active low): size registers to 320 x 240, counters and sums to
// zero, frame queue and result empty.
`default_nettype none
module frame_position_weighted_means #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [fpwm_pkg::IN_W-1:0]   i_pixel,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [fpwm_pkg::MI_W-1:0]        o_mean_intensity,
    output logic [fpwm_pkg::MW_W-1:0]        o_mean_column_weighted,
    output logic [fpwm_pkg::MW_W-1:0]        o_mean_row_weighted,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:2]                  paddr,
    input  wire logic [fpwm_pkg::APB_W-1:0]  pwdata,
    output logic [fpwm_pkg::APB_W-1:0]       prdata,
    output logic                             pready
);
    import fpwm_pkg::*;

    logic [CFG_W-1:0] r_width, r_height;
    logic             accept, fe_push, q_full, q_empty, q_pop;
    logic [Q_CW-1:0]  q_count;
    t_frame           fe_frame, q_data;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign full    = q_full;
    assign accept  = push && !full;

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_W'(r_width);
            REG_FRAME_HEIGHT: prdata = APB_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(320);
            r_height <= CFG_W'(240);
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    fpwm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (i_pixel),
        .i_width  (r_width),
        .i_height (r_height),
        .o_push   (fe_push),
        .o_frame  (fe_frame)
    );

    fpwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  (fe_frame),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    fpwm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_q_empty              (q_empty),
        .i_q_data               (q_data),
        .o_q_pop                (q_pop),
        .i_pop                  (pop),
        .o_empty                (empty),
        .o_mean_intensity       (o_mean_intensity),
        .o_mean_column_weighted (o_mean_column_weighted),
        .o_mean_row_weighted    (o_mean_row_weighted)
    );

    // a frame end never finds the queue without room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fe_push |-> !q_full)
        else $error("frame sums pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("frame queue popped while empty");

    // a new divide must not start over a result item still waiting
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> empty)
        else $error("divide started while result item pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |=> (q_count != '0) || $past(q_pop))
        else $error("frame queue count lost entries");

endmodule
`default_nettype wire
